@@ sv/ptsu_pkg.sv @@
// Shared types and constants for the PTP time stamp unit.
package ptsu_pkg;

    localparam int NS_BITS        = 30;
    localparam int CMP_NS_BITS    = 22;
    localparam int CFG_INDEX_BITS = 8;

    localparam logic [31:0] NS_WRAP    = 32'd1000000000;
    localparam logic [31:0] NS_WRAP_X2 = 32'd2000000000;
    localparam logic [31:0] NS_MAX     = 32'd999999999;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COMPARE_IRQ_EN = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PPS_IRQ_EN     = 8'd1;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        SEL_SECONDS     = 3'd0,
        SEL_NANOSECONDS = 3'd1,
        SEL_INCR_NS     = 3'd2,
        SEL_INCR_SUBNS  = 3'd3,
        SEL_ADJUST      = 3'd4,
        SEL_CMP_SEC     = 3'd5,
        SEL_CMP_NSEC    = 3'd6
    } reg_sel_t;

    typedef struct packed {
        mode_t       mode;
        reg_sel_t    reg_select;
        logic [31:0] write_data;
    } item_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        compare_hit;
        logic        second_pulse;
    } result_t;

endpackage

@@ sv/ptsu_in_stage.sv @@
// Input register stage: captures one beat from the slave side.
module ptsu_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [31:0]     s_tdata,   // write_data[31:0]
    input  logic [4:0]      s_tuser,   // mode[1:0], reg_select[4:2]
    input  logic            advance,
    output logic            item_valid,
    output ptsu_pkg::item_t item
);

    logic            valid_reg;
    ptsu_pkg::item_t item_reg;

    // Free when empty or when the held beat moves on this cycle
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode       <= ptsu_pkg::mode_t'(s_tuser[1:0]);
            item_reg.reg_select <= ptsu_pkg::reg_sel_t'(s_tuser[4:2]);
            item_reg.write_data <= s_tdata;
        end
    end

endmodule

@@ sv/ptsu_core.sv @@
// Timer state, register file and per-beat update logic.
module ptsu_core #(
    parameter int SUBNS_BITS   = 24,
    parameter int INCR_NS_BITS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [ptsu_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [31:0]                           cfg_data,
    input  logic                                  step,
    input  ptsu_pkg::item_t                       item,
    output ptsu_pkg::result_t                     result
);

    localparam int NSB = ptsu_pkg::NS_BITS;
    localparam int CNB = ptsu_pkg::CMP_NS_BITS;

    logic                    cmp_irq_en_reg;
    logic                    pps_irq_en_reg;
    logic [31:0]             sec_reg,       sec_next;
    logic [NSB-1:0]          ns_reg,        ns_next;
    logic [SUBNS_BITS-1:0]   subns_reg,     subns_next;
    logic [INCR_NS_BITS-1:0] inc_ns_reg,    inc_ns_next;
    logic [SUBNS_BITS-1:0]   inc_subns_reg, inc_subns_next;
    logic [31:0]             cmp_sec_reg,   cmp_sec_next;
    logic [CNB-1:0]          cmp_ns_reg,    cmp_ns_next;
    logic                    match_seen_reg, match_seen_next;

    logic [31:0]             wd;
    logic [SUBNS_BITS:0]     acc_sum;
    logic [NSB:0]            ns_sum;
    logic                    tick_wrap;
    logic [NSB-1:0]          tick_ns;
    logic [31:0]             tick_sec;
    logic                    tick_match;

    logic [23:0]             unpack_full;
    logic [23:0]             pack_full;
    logic [31:0]             packed_subns;

    logic [31:0]             ns32, adj_mag;
    logic [31:0]             pos_t, pos_t1, pos_t2;
    logic [31:0]             ns_p1, ns_p2;
    logic [31:0]             neg_direct, neg_t1, neg_t2;
    logic [31:0]             adj_sec;
    logic [NSB-1:0]          adj_ns;

    assign wd = item.write_data;

    // Tick: fraction carry feeds nanoseconds, one wrap at most per tick
    assign acc_sum   = {1'b0, subns_reg} + {1'b0, inc_subns_reg};
    assign ns_sum    = {1'b0, ns_reg} + (NSB+1)'(inc_ns_reg) + (NSB+1)'(acc_sum[SUBNS_BITS]);
    assign tick_wrap = ns_sum >= (NSB+1)'(ptsu_pkg::NS_WRAP);
    assign tick_ns   = tick_wrap ? NSB'(ns_sum - (NSB+1)'(ptsu_pkg::NS_WRAP)) : ns_sum[NSB-1:0];
    assign tick_sec  = sec_reg + 32'(tick_wrap);
    assign tick_match = (tick_sec == cmp_sec_reg) && (tick_ns[NSB-1:8] == cmp_ns_reg);

    // Packed fraction layout: bits 15:0 hold fraction 23:8, bits 31:24 hold 7:0
    assign unpack_full  = {wd[15:0], wd[31:24]};
    assign pack_full    = 24'(inc_subns_reg) << (24 - SUBNS_BITS);
    assign packed_subns = {pack_full[7:0], 8'd0, pack_full[23:8]};

    // Adjust: magnitude below 2^30 and ns below 1e9, so at most two seconds move
    assign ns32       = 32'(ns_reg);
    assign adj_mag    = {2'b00, wd[29:0]};
    assign pos_t      = ns32 + adj_mag;
    assign pos_t1     = pos_t - ptsu_pkg::NS_WRAP;
    assign pos_t2     = pos_t - ptsu_pkg::NS_WRAP_X2;
    assign ns_p1      = ns32 + ptsu_pkg::NS_WRAP;
    assign ns_p2      = ns32 + ptsu_pkg::NS_WRAP_X2;
    assign neg_direct = ns32 - adj_mag;
    assign neg_t1     = ns_p1 - adj_mag;
    assign neg_t2     = ns_p2 - adj_mag;

    always_comb begin
        adj_sec = sec_reg;
        adj_ns  = ns_reg;
        if (wd[31]) begin
            if (adj_mag <= ns32) begin
                adj_ns = neg_direct[NSB-1:0];
            end else if (adj_mag <= ns_p1) begin
                adj_sec = sec_reg - 32'd1;
                adj_ns  = neg_t1[NSB-1:0];
            end else begin
                adj_sec = sec_reg - 32'd2;
                adj_ns  = neg_t2[NSB-1:0];
            end
        end else begin
            if (pos_t >= ptsu_pkg::NS_WRAP_X2) begin
                adj_sec = sec_reg + 32'd2;
                adj_ns  = pos_t2[NSB-1:0];
            end else if (pos_t >= ptsu_pkg::NS_WRAP) begin
                adj_sec = sec_reg + 32'd1;
                adj_ns  = pos_t1[NSB-1:0];
            end else begin
                adj_ns  = pos_t[NSB-1:0];
            end
        end
    end

    always_comb begin
        sec_next        = sec_reg;
        ns_next         = ns_reg;
        subns_next      = subns_reg;
        inc_ns_next     = inc_ns_reg;
        inc_subns_next  = inc_subns_reg;
        cmp_sec_next    = cmp_sec_reg;
        cmp_ns_next     = cmp_ns_reg;
        match_seen_next = match_seen_reg;
        result          = '0;
        case (item.mode)
            ptsu_pkg::MODE_TICK: begin
                subns_next          = acc_sum[SUBNS_BITS-1:0];
                ns_next             = tick_ns;
                sec_next            = tick_sec;
                match_seen_next     = tick_match;
                result.second_pulse = tick_wrap && pps_irq_en_reg;
                result.compare_hit  = tick_match && !match_seen_reg && cmp_irq_en_reg;
            end
            ptsu_pkg::MODE_WRITE: begin
                case (item.reg_select)
                    ptsu_pkg::SEL_SECONDS:     sec_next = wd;
                    ptsu_pkg::SEL_NANOSECONDS: begin
                        ns_next = (wd > ptsu_pkg::NS_MAX) ? NSB'(ptsu_pkg::NS_MAX)
                                                          : wd[NSB-1:0];
                    end
                    ptsu_pkg::SEL_INCR_NS:     inc_ns_next = wd[INCR_NS_BITS-1:0];
                    ptsu_pkg::SEL_INCR_SUBNS:  inc_subns_next = unpack_full[23 -: SUBNS_BITS];
                    ptsu_pkg::SEL_ADJUST: begin
                        sec_next = adj_sec;
                        ns_next  = adj_ns;
                    end
                    ptsu_pkg::SEL_CMP_SEC:     cmp_sec_next = wd;
                    ptsu_pkg::SEL_CMP_NSEC:    cmp_ns_next = wd[CNB-1:0];
                    default: ;
                endcase
            end
            ptsu_pkg::MODE_READ: begin
                case (item.reg_select)
                    ptsu_pkg::SEL_SECONDS:     result.read_data = sec_reg;
                    ptsu_pkg::SEL_NANOSECONDS: result.read_data = 32'(ns_reg);
                    ptsu_pkg::SEL_INCR_NS:     result.read_data = 32'(inc_ns_reg);
                    ptsu_pkg::SEL_INCR_SUBNS:  result.read_data = packed_subns;
                    ptsu_pkg::SEL_CMP_SEC:     result.read_data = cmp_sec_reg;
                    ptsu_pkg::SEL_CMP_NSEC:    result.read_data = 32'(cmp_ns_reg);
                    default:                   result.read_data = 32'd0;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_irq_en_reg <= 1'b0;
            pps_irq_en_reg <= 1'b0;
        end else if (cfg_valid) begin
            if (cfg_index == ptsu_pkg::CFG_COMPARE_IRQ_EN) begin
                cmp_irq_en_reg <= cfg_data[0];
            end
            if (cfg_index == ptsu_pkg::CFG_PPS_IRQ_EN) begin
                pps_irq_en_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg        <= '0;
            ns_reg         <= '0;
            subns_reg      <= '0;
            inc_ns_reg     <= '0;
            inc_subns_reg  <= '0;
            cmp_sec_reg    <= '0;
            cmp_ns_reg     <= '0;
            match_seen_reg <= 1'b0;
        end else if (step) begin
            sec_reg        <= sec_next;
            ns_reg         <= ns_next;
            subns_reg      <= subns_next;
            inc_ns_reg     <= inc_ns_next;
            inc_subns_reg  <= inc_subns_next;
            cmp_sec_reg    <= cmp_sec_next;
            cmp_ns_reg     <= cmp_ns_next;
            match_seen_reg <= match_seen_next;
        end
    end

`ifndef SYNTHESIS
    a_ns_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ns_reg) < ptsu_pkg::NS_WRAP)
        else $error("nanoseconds left the 0..999999999 range");

    a_hit_sets_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.compare_hit |=> match_seen_reg)
        else $error("compare hit without match tracking");

    a_hit_needs_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.compare_hit |-> !match_seen_reg)
        else $error("compare hit on a repeated match");

    a_time_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(sec_reg) && $stable(ns_reg) && $stable(subns_reg))
        else $error("time moved without a beat");

    a_pulse_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        step && (result.second_pulse || result.compare_hit) |->
            item.mode == ptsu_pkg::MODE_TICK)
        else $error("event flag on a register access");
`endif

endmodule

@@ sv/ptsu_out_stage.sv @@
// Result register stage: holds one beat for the master side.
module ptsu_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  ptsu_pkg::result_t result,
    output logic              out_busy,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,   // read_data[31:0]
    output logic [1:0]        m_tuser    // compare_hit[0], second_pulse[1]
);

    logic              valid_reg;
    ptsu_pkg::result_t result_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = result_reg.read_data;
    assign m_tuser  = {result_reg.second_pulse, result_reg.compare_hit};
    // Busy while a beat waits that is not taken this cycle
    assign out_busy = valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule

@@ sv/ptp_timestamp_unit_top.sv @@
// PTP time stamp unit: one beat per cycle while the master side takes results.
// Each input beat is a clock tick, a register write or a register read, and gives exactly one
// result beat. A beat is captured in an input register; the update logic between that register
// and the result register then updates the timer state and loads the result register from it, so one
// beat is taken every cycle while the master side takes results.
// The unit stalls only when the result register is full and not being taken.
// The two interrupt enables are written over the cfg channel (index 0 compare, 1 pulse);
// cfg_ready is always high.
module ptp_timestamp_unit_top #(
    parameter int SUBNS_BITS   = 24,
    parameter int INCR_NS_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [31:0]                         s_tdata,   // write_data[31:0]
    input  logic [4:0]                          s_tuser,   // mode[1:0], reg_select[4:2]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // read_data[31:0]
    output logic [1:0]                          m_tuser,   // compare_hit[0], second_pulse[1]
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [31:0]                         cfg_data
);

    logic              item_valid;
    ptsu_pkg::item_t   item;
    ptsu_pkg::result_t result;
    logic              out_busy;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid && !out_busy;

    ptsu_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ptsu_core #(
        .SUBNS_BITS   (SUBNS_BITS),
        .INCR_NS_BITS (INCR_NS_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item),
        .result    (result)
    );

    ptsu_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .result   (result),
        .out_busy (out_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
